FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CCD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ccd_pkg.sv
// Shared types and constants of the character constant decoder.
package ccd_pkg;

  localparam int unsigned TokenDepthDefault  = 4;
  localparam int unsigned ResultDepthDefault = 2;

  localparam logic [1:0] ST_QUOTE   = 2'd0;
  localparam logic [1:0] ST_EOI_BODY = 2'd1;
  localparam logic [1:0] ST_EOI_ESC = 2'd2;

  // One classified source byte.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       eoi;
    logic       is_quote;
    logic       is_bslash;
    logic       is_oct;
    logic       is_x;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic [7:0] esc_map;
  } token_t;

  // One decoded constant.
  typedef struct packed {
    logic [31:0] const_value;
    logic [1:0]  status;
    logic        empty_hex_escape;
  } result_t;

endpackage

FILE: rtl/core/ccd_fifo.sv
// Small first-in first-out queue used between the decoder stages.
module ccd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/ccd_front.sv
// Front end: classifies each incoming byte into a token for the scanner.
module ccd_front (
  input  logic            [7:0] byte_in,
  input  logic                  end_of_input,
  output ccd_pkg::token_t       tok
);
  import ccd_pkg::*;

  logic [7:0] b;
  logic       live;

  assign b    = byte_in;
  assign live = !end_of_input;

  always_comb begin
    tok           = '0;
    tok.byte_val  = b;
    tok.eoi       = end_of_input;
    tok.is_quote  = live && (b == 8'h27);
    tok.is_bslash = live && (b == 8'h5C);
    tok.is_oct    = live && (b >= 8'h30) && (b <= 8'h37);
    tok.is_x      = live && ((b == 8'h78) || (b == 8'h58));
    if (live && (b >= 8'h30) && (b <= 8'h39)) begin
      tok.hex_ok  = 1'b1;
      tok.hex_val = b[3:0];
    end else if (live && (((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46)))) begin
      // letters a-f and A-F share their low three bits: 1..6 maps to 10..15
      tok.hex_ok  = 1'b1;
      tok.hex_val = 4'(4'd9 + {1'b0, b[2:0]});
    end
    case (b)
      8'h62:   tok.esc_map = 8'd8;
      8'h66:   tok.esc_map = 8'd12;
      8'h6E:   tok.esc_map = 8'd10;
      8'h72:   tok.esc_map = 8'd13;
      8'h74:   tok.esc_map = 8'd9;
      8'h76:   tok.esc_map = 8'd11;
      default: tok.esc_map = b;
    endcase
  end

endmodule

FILE: rtl/core/ccd_back.sv
// Back end: scans tokens through the constant and escape states and builds results.
module ccd_back (
  input  logic             clk,
  input  logic             rst,
  input  ccd_pkg::token_t  tok,
  input  logic             tok_empty,
  output logic             tok_pop,
  input  logic             res_full,
  output logic             res_push,
  output ccd_pkg::result_t res_data
);
  import ccd_pkg::*;

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_BODY = 5'b00010,
    M_ESC  = 5'b00100,
    M_OCT  = 5'b01000,
    M_HEX  = 5'b10000
  } mode_t;

  mode_t       mode, mode_next;
  logic [31:0] value_acc, value_acc_next;
  logic [7:0]  escape_acc, escape_acc_next;
  logic [1:0]  escape_digits, escape_digits_next;
  logic        empty_hex_seen, empty_hex_seen_next;
  logic        do_body;
  logic        emit;
  logic [1:0]  emit_status;

  // A token moves only when there is room for the result it might make.
  assign tok_pop = !tok_empty && !res_full;

  always_comb begin
    mode_next           = mode;
    value_acc_next      = value_acc;
    escape_acc_next     = escape_acc;
    escape_digits_next  = escape_digits;
    empty_hex_seen_next = empty_hex_seen;
    do_body             = 1'b0;
    emit                = 1'b0;
    emit_status         = ST_QUOTE;
    if (tok_pop) begin
      case (mode)
        M_IDLE: begin
          if (tok.is_quote) begin
            value_acc_next      = '0;
            escape_acc_next     = '0;
            escape_digits_next  = '0;
            empty_hex_seen_next = 1'b0;
            mode_next           = M_BODY;
          end
        end
        M_BODY: do_body = 1'b1;
        M_ESC: begin
          if (tok.eoi) begin
            value_acc_next = {value_acc[23:0], 8'h00};
            emit           = 1'b1;
            emit_status    = ST_EOI_ESC;
            mode_next      = M_IDLE;
          end else if (tok.is_oct) begin
            escape_acc_next    = {5'b0, tok.byte_val[2:0]};
            escape_digits_next = 2'd1;
            mode_next          = M_OCT;
          end else if (tok.is_x) begin
            escape_acc_next    = '0;
            escape_digits_next = '0;
            mode_next          = M_HEX;
          end else begin
            value_acc_next = {value_acc[23:0], tok.esc_map};
            mode_next      = M_BODY;
          end
        end
        M_OCT: begin
          if (tok.is_oct) begin
            escape_acc_next    = {escape_acc[4:0], tok.byte_val[2:0]};
            escape_digits_next = escape_digits + 2'd1;
            if (escape_digits == 2'd2) begin
              value_acc_next = {value_acc[23:0], escape_acc[4:0], tok.byte_val[2:0]};
              mode_next      = M_BODY;
            end
          end else begin
            value_acc_next = {value_acc[23:0], escape_acc};
            mode_next      = M_BODY;
            do_body        = 1'b1;
          end
        end
        M_HEX: begin
          if (tok.hex_ok) begin
            escape_acc_next    = {escape_acc[3:0], tok.hex_val};
            escape_digits_next = escape_digits + 2'd1;
            if (escape_digits == 2'd1) begin
              value_acc_next = {value_acc[23:0], escape_acc[3:0], tok.hex_val};
              mode_next      = M_BODY;
            end
          end else begin
            if (escape_digits == 2'd0) begin
              empty_hex_seen_next = 1'b1;
            end
            value_acc_next = {value_acc[23:0], escape_acc};
            mode_next      = M_BODY;
            do_body        = 1'b1;
          end
        end
        default: mode_next = M_IDLE;
      endcase

      // Body handling; also reprocesses the byte that ended an escape.
      if (do_body) begin
        if (tok.eoi) begin
          emit        = 1'b1;
          emit_status = ST_EOI_BODY;
          mode_next   = M_IDLE;
        end else if (tok.is_quote) begin
          emit        = 1'b1;
          emit_status = ST_QUOTE;
          mode_next   = M_IDLE;
        end else if (tok.is_bslash) begin
          mode_next = M_ESC;
        end else begin
          value_acc_next = {value_acc_next[23:0], tok.byte_val};
        end
      end
    end
  end

  assign res_push                  = emit;
  assign res_data.const_value      = value_acc_next;
  assign res_data.status           = emit_status;
  assign res_data.empty_hex_escape = empty_hex_seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= M_IDLE;
      value_acc      <= '0;
      escape_acc     <= '0;
      escape_digits  <= '0;
      empty_hex_seen <= 1'b0;
    end else begin
      mode           <= mode_next;
      value_acc      <= value_acc_next;
      escape_acc     <= escape_acc_next;
      escape_digits  <= escape_digits_next;
      empty_hex_seen <= empty_hex_seen_next;
    end
  end

endmodule

FILE: rtl/core/c_char_constant_decoder_top.sv
// C character constant decoder: bytes of source text in, decoded constants out.
//
// Input channel: present byte_in and end_of_input with push; the transaction
// completes on a clock edge with push high and full low. Bytes outside a
// constant are dropped; a quote opens a constant.
// Result channel: while empty is low, const_value, status and
// empty_hex_escape hold the oldest constant; pop takes it on a clock edge.
// A result reaches the result ports after the transaction that closes the
// constant (the closing quote or end_of_input): the token queue takes the byte
// at that edge, and the scanner writes the result queue when it pops that token.
// Throughput: one byte per cycle, held while the result queue is full. The front
// classifies each byte into the token queue; the scanner drains it one token a
// cycle whenever the result queue has room.
// Receiver stall: the scanner holds while the result queue is full; the token
// queue then fills and full rises after at most TOKEN_DEPTH more bytes.
// Reset (rst, synchronous): both queues empty, scanner idle, value cleared.
module c_char_constant_decoder_top #(
  parameter int unsigned TOKEN_DEPTH  = ccd_pkg::TokenDepthDefault,
  parameter int unsigned RESULT_DEPTH = ccd_pkg::ResultDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  byte_in,
  input  logic        end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] const_value,
  output logic [1:0]  status,
  output logic        empty_hex_escape
);
  import ccd_pkg::*;
  `include "assert_macros.svh"

  token_t  tok_in;
  token_t  tok_out;
  logic    tok_empty;
  logic    tok_pop;
  logic    res_full;
  logic    res_push;
  result_t res_in;
  result_t res_out;

  ccd_front u_front (
    .byte_in      (byte_in),
    .end_of_input (end_of_input),
    .tok          (tok_in)
  );

  ccd_fifo #(
    .WIDTH ($bits(token_t)),
    .DEPTH (TOKEN_DEPTH)
  ) u_tok_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (tok_in),
    .rd_en   (tok_pop),
    .rd_data (tok_out),
    .full    (full),
    .empty   (tok_empty)
  );

  ccd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (tok_out),
    .tok_empty (tok_empty),
    .tok_pop   (tok_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  ccd_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .rd_en   (pop),
    .rd_data (res_out),
    .full    (res_full),
    .empty   (empty)
  );

  assign const_value      = res_out.const_value;
  assign status           = res_out.status;
  assign empty_hex_escape = res_out.empty_hex_escape;

  `CCD_ASSERT_SAME(a_res_room, res_push, !res_full, "result written into a full queue")
  `CCD_ASSERT_SAME(a_tok_avail, res_push, !tok_empty, "result made without a token")
  `CCD_ASSERT_SAME(a_status_code, res_push, res_in.status != 2'd3, "undefined status code")
  `CCD_ASSERT_NEXT(a_reset_empty, rst, empty, "result queue not empty after reset")

endmodule
